// ===== hw/rtl/touch_cursor_delta_smoother_top_macros.svh =====
// Assertion macros shared by the checker of the cursor smoother.
`ifndef TOUCH_CURSOR_DELTA_SMOOTHER_TOP_MACROS_SVH
`define TOUCH_CURSOR_DELTA_SMOOTHER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCDS_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcds_pkg.sv =====
`timescale 1ns / 1ps

package tcds_pkg;

  // Geometry of the block.
  localparam int HIST_DEPTH  = 10;
  localparam int NUM_FINGERS = 5;

  // Limits and scale factors.
  localparam int DELTA_LIM   = 300;
  localparam int MOVE_THRESH = 2;
  localparam int HID_LIM     = 127;
  localparam int LIN_SCALE   = 10;
  localparam int ACC_SCALE   = 100;

  // Field widths.
  localparam int COORD_W   = 16;
  localparam int STR_W     = 16;
  localparam int FINGER_W  = STR_W + 2 * COORD_W;
  localparam int DELTA_W   = 10;
  localparam int MOUSE_W   = 8;
  localparam int COUNT_W   = 3;
  localparam int MS_W      = 16;
  localparam int LEN_CFG_W = 4;
  localparam int GAIN_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Derived widths.
  localparam int AF_W    = $clog2(NUM_FINGERS + 1);
  localparam int LEN_W   = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W   = $clog2(HIST_DEPTH);
  localparam int SUM_W   = $clog2(HIST_DEPTH * DELTA_LIM + 1) + 1;
  localparam int P1_W    = SUM_W + GAIN_W;
  localparam int P2_W    = P1_W + SUM_W - 1;
  localparam int TOT_W   = P2_W + 1;
  localparam int MAG_W   = TOT_W - 1;
  localparam int DIV_W   = $clog2(ACC_SCALE * HIST_DEPTH + 1);
  localparam int CARRY_W = DIV_W + 1;
  localparam int DCNT_W  = $clog2(MAG_W + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTH_LEN  = 3'd0,
    CFG_ACCEL_ON    = 3'd1,
    CFG_SPEED_GAIN  = 3'd2,
    CFG_WAIT_SINGLE = 3'd3,
    CFG_WAIT_MULTI  = 3'd4
  } cfg_idx_t;

  // What one finger lane found for the current report.
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [STR_W-1:0]          strength;
  } lane_res_t;

  // Merged selection for the current report.
  typedef struct packed {
    logic signed [DELTA_W-1:0] sx;
    logic signed [DELTA_W-1:0] sy;
    logic [STR_W-1:0]          peak;
    logic [COUNT_W-1:0]        count;
  } sel_res_t;

  // Result of one smoothing axis.
  typedef struct packed {
    logic signed [MOUSE_W-1:0] mouse;
    logic signed [MOUSE_W-1:0] prior;
    logic signed [DELTA_W-1:0] last_delta;
  } axis_res_t;

  // Smoothing settings shared by both axes.
  typedef struct packed {
    logic [LEN_CFG_W-1:0] smooth_len;
    logic                 accel_on;
    logic [GAIN_W-1:0]    speed_gain;
  } smooth_cfg_t;

endpackage

// ===== hw/rtl/tcds_finger_lane.sv =====
`timescale 1ns / 1ps

module tcds_finger_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          capture,
  input  logic [tcds_pkg::FINGER_W-1:0] finger,
  output logic                          had_prev,
  output tcds_pkg::lane_res_t           res
);
  import tcds_pkg::*;

  logic [COORD_W-1:0]        fx;
  logic [COORD_W-1:0]        fy;
  logic [STR_W-1:0]          st;
  logic [COORD_W-1:0]        prev_x_r;
  logic [COORD_W-1:0]        prev_y_r;
  logic                      valid_r;
  logic signed [COORD_W:0]   diff_x;
  logic signed [COORD_W:0]   diff_y;
  lane_res_t                 res_r;

  function automatic logic signed [DELTA_W-1:0] clamp_delta(input logic signed [COORD_W:0] d);
    if (d > (COORD_W + 1)'(DELTA_LIM)) begin
      return DELTA_W'(DELTA_LIM);
    end else if (d < (COORD_W + 1)'(-DELTA_LIM)) begin
      return DELTA_W'(-DELTA_LIM);
    end
    return DELTA_W'(d);
  endfunction

  // Unpack the finger beat.
  assign fx = finger[COORD_W-1:0];
  assign fy = finger[2*COORD_W-1:COORD_W];
  assign st = finger[FINGER_W-1:2*COORD_W];

  assign diff_x   = $signed({1'b0, fx}) - $signed({1'b0, prev_x_r});
  assign diff_y   = $signed({1'b0, fy}) - $signed({1'b0, prev_y_r});
  assign had_prev = (st != '0) && valid_r;

  // A finger with zero strength forgets its position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (capture) begin
      valid_r <= (st != '0);
    end
  end

  // Delta against the stored position, then store the new one.
  always_ff @(posedge clk) begin
    if (capture) begin
      res_r.strength <= st;
      if (had_prev) begin
        res_r.dx <= clamp_delta(diff_x);
        res_r.dy <= clamp_delta(diff_y);
      end else begin
        res_r.dx <= '0;
        res_r.dy <= '0;
      end
      if (st != '0) begin
        prev_x_r <= fx;
        prev_y_r <= fy;
      end
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/tcds_merge.sv =====
`timescale 1ns / 1ps

module tcds_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             capture,
  input  logic                             select,
  input  tcds_pkg::lane_res_t              lanes [tcds_pkg::NUM_FINGERS],
  input  logic [tcds_pkg::NUM_FINGERS-1:0] had_prev,
  input  logic [tcds_pkg::COUNT_W-1:0]     count,
  input  logic [tcds_pkg::MS_W-1:0]        now_ms,
  input  logic [tcds_pkg::MS_W-1:0]        wait_single,
  input  logic [tcds_pkg::MS_W-1:0]        wait_multi,
  output tcds_pkg::sel_res_t               sel
);
  import tcds_pkg::*;

  logic [AF_W-1:0]           active_r;
  logic [AF_W-1:0]           active_nxt;
  logic [MS_W-1:0]           touch_start_r;
  logic [MS_W-1:0]           now_r;
  logic [COUNT_W-1:0]        count_r;
  logic [MS_W-1:0]           elapsed;
  logic                      hold;
  logic [NUM_FINGERS-1:0]    moving;
  logic                      act_moving;
  logic signed [DELTA_W-1:0] act_dx;
  logic signed [DELTA_W-1:0] act_dy;
  logic [AF_W-1:0]           first;
  logic [STR_W-1:0]          peak;
  sel_res_t                  sel_r;
  sel_res_t                  sel_nxt;

  function automatic logic [DELTA_W-1:0] abs_delta(input logic signed [DELTA_W-1:0] d);
    return (d < 0) ? DELTA_W'(-d) : DELTA_W'(d);
  endfunction

  // A fresh touch restarts the hold timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_start_r <= '0;
    end else if (capture && (count != '0) && (had_prev == '0)) begin
      touch_start_r <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      now_r   <= now_ms;
      count_r <= count;
    end
  end

  // Motion flags, active finger lookup, lowest moving finger and peak strength.
  always_comb begin
    act_moving = 1'b0;
    act_dx     = '0;
    act_dy     = '0;
    first      = AF_W'(NUM_FINGERS);
    peak       = '0;
    for (int i = 0; i < NUM_FINGERS; i++) begin
      moving[i] = ((DELTA_W + 1)'(abs_delta(lanes[i].dx)) + (DELTA_W + 1)'(abs_delta(lanes[i].dy)))
                  > (DELTA_W + 1)'(MOVE_THRESH);
      if (AF_W'(i) == active_r) begin
        act_moving = moving[i];
        act_dx     = lanes[i].dx;
        act_dy     = lanes[i].dy;
      end
      if (lanes[i].strength > peak) begin
        peak = lanes[i].strength;
      end
    end
    for (int i = NUM_FINGERS - 1; i >= 0; i--) begin
      if (moving[i]) begin
        first = AF_W'(i);
      end
    end
  end

  // Hold after a fresh touch, stick to the active finger, drop a switch.
  always_comb begin
    elapsed    = now_r - touch_start_r;
    hold       = ((count_r == COUNT_W'(1)) && (elapsed < wait_single)) ||
                 ((count_r >= COUNT_W'(2)) && (elapsed < wait_multi));
    active_nxt = active_r;
    sel_nxt.sx = '0;
    sel_nxt.sy = '0;
    if (!hold) begin
      if (act_moving) begin
        sel_nxt.sx = act_dx;
        sel_nxt.sy = act_dy;
      end else begin
        active_nxt = first;
      end
    end
    sel_nxt.peak  = peak;
    sel_nxt.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (select) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (select) begin
      sel_r <= sel_nxt;
    end
  end

  assign sel = sel_r;

endmodule

// ===== hw/rtl/tcds_axis.sv =====
`timescale 1ns / 1ps

module tcds_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tcds_pkg::DELTA_W-1:0] delta,
  input  tcds_pkg::smooth_cfg_t               cfg,
  output logic                                done,
  output tcds_pkg::axis_res_t                 res
);
  import tcds_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE, A_SUM, A_MUL1, A_MUL2, A_ADD, A_DIV, A_FIN, A_DONE
  } axis_state_t;

  axis_state_t               st_r;
  logic signed [DELTA_W-1:0] hist_r [HIST_DEPTH];
  logic signed [CARRY_W-1:0] carry_r;
  logic signed [MOUSE_W-1:0] last_mouse_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic [LEN_W-1:0]          idx_r;
  logic [LEN_W-1:0]          len_r;
  logic [DIV_W-1:0]          divisor_r;
  logic signed [P1_W-1:0]    p1_r;
  logic [SUM_W-2:0]          mag_r;
  logic signed [P2_W-1:0]    p2_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          dvd_r;
  logic [DIV_W-1:0]          rem_r;
  logic [DCNT_W-1:0]         cnt_r;
  axis_res_t                 res_r;

  logic [LEN_W-1:0]          len_c;
  logic [DIV_W-1:0]          div_c;
  logic signed [P2_W-1:0]    prod2;
  logic signed [TOT_W-1:0]   tot;
  logic [DIV_W:0]            rem_sh;
  logic                      qbit;
  logic [DIV_W-1:0]          rem_n;
  logic [MOUSE_W-2:0]        cap;
  logic [MOUSE_W-2:0]        mag_out;
  logic signed [MOUSE_W-1:0] mouse_c;
  logic signed [CARRY_W-1:0] carry_c;

  // Window length clamped into range, and the matching divisor.
  always_comb begin
    if (cfg.smooth_len == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(cfg.smooth_len) > HIST_DEPTH) begin
      len_c = LEN_W'(HIST_DEPTH);
    end else begin
      len_c = LEN_W'(cfg.smooth_len);
    end
    if (cfg.accel_on) begin
      div_c = DIV_W'(len_c * ACC_SCALE);
    end else begin
      div_c = DIV_W'(len_c * LIN_SCALE);
    end
  end

  // Second gain multiply and carry add.
  assign prod2 = P2_W'(p1_r) * P2_W'($signed({1'b0, mag_r}));
  assign tot   = TOT_W'(p2_r) + TOT_W'(carry_r);

  // One restoring division step.
  assign rem_sh = {rem_r, dvd_r[MAG_W-1]};
  assign qbit   = (rem_sh >= {1'b0, divisor_r});
  assign rem_n  = qbit ? DIV_W'(rem_sh - {1'b0, divisor_r}) : DIV_W'(rem_sh);

  // Quotient clamp, sign restore and new carry.
  always_comb begin
    if (cfg.accel_on && (cfg.speed_gain == '0)) begin
      cap = '0;
    end else if (cfg.accel_on && (cfg.speed_gain == GAIN_W'(1))) begin
      cap = (MOUSE_W - 1)'(ACC_SCALE);
    end else begin
      cap = (MOUSE_W - 1)'(HID_LIM);
    end
    if (dvd_r > MAG_W'(cap)) begin
      mag_out = cap;
    end else begin
      mag_out = dvd_r[MOUSE_W-2:0];
    end
    mouse_c = neg_r ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    carry_c = neg_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
  end

  // Sequencer: window sum, gain multiply, a second multiply when acceleration is on, carry add, serial divide, update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= A_IDLE;
      hist_r       <= '{default: '0};
      carry_r      <= '0;
      last_mouse_r <= '0;
    end else begin
      case (st_r)
        A_IDLE, A_DONE: begin
          if (start) begin
            acc_r     <= SUM_W'(delta);
            delta_r   <= delta;
            idx_r     <= '0;
            len_r     <= len_c;
            divisor_r <= div_c;
            st_r      <= A_SUM;
          end
        end
        A_SUM: begin
          if (idx_r < len_r - LEN_W'(1)) begin
            acc_r <= acc_r + SUM_W'(hist_r[idx_r[IDX_W-1:0]]);
            idx_r <= idx_r + LEN_W'(1);
          end else begin
            st_r <= A_MUL1;
          end
        end
        A_MUL1: begin
          p1_r  <= P1_W'(acc_r) * P1_W'($signed({1'b0, cfg.speed_gain}));
          mag_r <= (acc_r < 0) ? (SUM_W - 1)'(-acc_r) : (SUM_W - 1)'(acc_r);
          st_r  <= A_MUL2;
        end
        A_MUL2: begin
          p2_r <= cfg.accel_on ? prod2 : P2_W'(p1_r);
          st_r <= A_ADD;
        end
        A_ADD: begin
          neg_r <= tot[TOT_W-1];
          dvd_r <= tot[TOT_W-1] ? MAG_W'(-tot) : MAG_W'(tot);
          rem_r <= '0;
          cnt_r <= DCNT_W'(MAG_W);
          st_r  <= A_DIV;
        end
        A_DIV: begin
          dvd_r <= {dvd_r[MAG_W-2:0], qbit};
          rem_r <= rem_n;
          cnt_r <= cnt_r - DCNT_W'(1);
          if (cnt_r == DCNT_W'(1)) begin
            st_r <= A_FIN;
          end
        end
        A_FIN: begin
          res_r.mouse      <= mouse_c;
          res_r.prior      <= last_mouse_r;
          res_r.last_delta <= hist_r[0];
          for (int i = HIST_DEPTH - 1; i >= 1; i--) begin
            hist_r[i] <= hist_r[i-1];
          end
          hist_r[0]    <= delta_r;
          last_mouse_r <= mouse_c;
          carry_r      <= carry_c;
          st_r         <= A_DONE;
        end
        default: begin
          st_r <= A_IDLE;
        end
      endcase
    end
  end

  assign done = (st_r == A_DONE);
  assign res  = res_r;

endmodule

// ===== hw/rtl/touch_cursor_delta_smoother_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in_       in_valid / in_stall      in_finger_a..e, in_finger_count, in_now_ms
// out_      out_valid / out_stall    deltas, mouse, prior mouse, peak, count
// cfg_      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One report is worked at a time. Each axis sums a window of L deltas, L being
// smooth_len clamped into 1..10, then runs a 32-step serial divider; out_valid
// rises once the result moves into the output register, when that is free.
// in_stall is high from the input beat until the result moves into the output
// register; the input then takes a new beat even while that result is stalled.
// Reset (rst_n low, synchronous) clears finger tracking, history, carries and
// the configuration to its defaults; cfg_ready is always high.

module touch_cursor_delta_smoother_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcds_pkg::FINGER_W-1:0]       in_finger_a,
  input  logic [tcds_pkg::FINGER_W-1:0]       in_finger_b,
  input  logic [tcds_pkg::FINGER_W-1:0]       in_finger_c,
  input  logic [tcds_pkg::FINGER_W-1:0]       in_finger_d,
  input  logic [tcds_pkg::FINGER_W-1:0]       in_finger_e,
  input  logic [tcds_pkg::COUNT_W-1:0]        in_finger_count,
  input  logic [tcds_pkg::MS_W-1:0]           in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tcds_pkg::DELTA_W-1:0] out_sel_delta_x,
  output logic signed [tcds_pkg::DELTA_W-1:0] out_sel_delta_y,
  output logic signed [tcds_pkg::DELTA_W-1:0] out_last_delta_x,
  output logic signed [tcds_pkg::DELTA_W-1:0] out_last_delta_y,
  output logic signed [tcds_pkg::MOUSE_W-1:0] out_mouse_x,
  output logic signed [tcds_pkg::MOUSE_W-1:0] out_mouse_y,
  output logic signed [tcds_pkg::MOUSE_W-1:0] out_prior_mouse_x,
  output logic signed [tcds_pkg::MOUSE_W-1:0] out_prior_mouse_y,
  output logic [tcds_pkg::STR_W-1:0]          out_peak_strength,
  output logic [tcds_pkg::COUNT_W-1:0]        out_count_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcds_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import tcds_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_SEL, T_START, T_WAIT} top_state_t;

  top_state_t              state_r;
  logic                    out_valid_r;
  smooth_cfg_t             scfg_r;
  logic [MS_W-1:0]         wait_single_r;
  logic [MS_W-1:0]         wait_multi_r;
  logic [FINGER_W-1:0]     fingers [NUM_FINGERS];
  lane_res_t               lanes [NUM_FINGERS];
  logic [NUM_FINGERS-1:0]  had_prev;
  sel_res_t                sel;
  logic                    accept;
  logic                    done_x;
  logic                    done_y;
  axis_res_t               res_x;
  axis_res_t               res_y;
  logic                    load;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != T_IDLE);
  assign cfg_ready = 1'b1;
  assign load      = (state_r == T_WAIT) && done_x && done_y && (!out_valid_r || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scfg_r.smooth_len <= LEN_CFG_W'(4);
      scfg_r.accel_on   <= 1'b0;
      scfg_r.speed_gain <= GAIN_W'(10);
      wait_single_r     <= MS_W'(50);
      wait_multi_r      <= MS_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SMOOTH_LEN:  scfg_r.smooth_len <= cfg_data[LEN_CFG_W-1:0];
        CFG_ACCEL_ON:    scfg_r.accel_on   <= cfg_data[0];
        CFG_SPEED_GAIN:  scfg_r.speed_gain <= cfg_data[GAIN_W-1:0];
        CFG_WAIT_SINGLE: wait_single_r     <= cfg_data;
        CFG_WAIT_MULTI:  wait_multi_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One lane per finger.
  assign fingers[0] = in_finger_a;
  assign fingers[1] = in_finger_b;
  assign fingers[2] = in_finger_c;
  assign fingers[3] = in_finger_d;
  assign fingers[4] = in_finger_e;

  for (genvar g = 0; g < NUM_FINGERS; g++) begin : g_lane
    tcds_finger_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .capture  (accept),
      .finger   (fingers[g]),
      .had_prev (had_prev[g]),
      .res      (lanes[g])
    );
  end

  tcds_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .capture     (accept),
    .select      (state_r == T_SEL),
    .lanes       (lanes),
    .had_prev    (had_prev),
    .count       (in_finger_count),
    .now_ms      (in_now_ms),
    .wait_single (wait_single_r),
    .wait_multi  (wait_multi_r),
    .sel         (sel)
  );

  tcds_axis u_axis_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == T_START),
    .delta (sel.sx),
    .cfg   (scfg_r),
    .done  (done_x),
    .res   (res_x)
  );

  tcds_axis u_axis_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == T_START),
    .delta (sel.sy),
    .cfg   (scfg_r),
    .done  (done_y),
    .res   (res_y)
  );

  // Report sequencing and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            state_r <= T_SEL;
          end
        end
        T_SEL: begin
          state_r <= T_START;
        end
        T_START: begin
          state_r <= T_WAIT;
        end
        T_WAIT: begin
          if (load) begin
            out_sel_delta_x   <= sel.sx;
            out_sel_delta_y   <= sel.sy;
            out_last_delta_x  <= res_x.last_delta;
            out_last_delta_y  <= res_y.last_delta;
            out_mouse_x       <= res_x.mouse;
            out_mouse_y       <= res_y.mouse;
            out_prior_mouse_x <= res_x.prior;
            out_prior_mouse_y <= res_y.prior;
            out_peak_strength <= sel.peak;
            out_count_out     <= sel.count;
            state_r           <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/tcds_checker.sv =====
`timescale 1ns / 1ps
`include "touch_cursor_delta_smoother_top_macros.svh"

module tcds_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [tcds_pkg::DELTA_W-1:0] out_sel_delta_x,
  input logic signed [tcds_pkg::DELTA_W-1:0] out_sel_delta_y,
  input logic signed [tcds_pkg::MOUSE_W-1:0] out_mouse_x,
  input logic signed [tcds_pkg::MOUSE_W-1:0] out_mouse_y
);

  // A stalled result beat keeps its cursor movement.
  `TCDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_mouse_x) && $stable(out_mouse_y), "stalled result changed")

  // A report is worked alone, so the input is busy right after a beat.
  `TCDS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

  // Cursor movement stays inside the HID range.
  `TCDS_ASSERT_HOLDS(a_mouse_range, out_valid, out_mouse_x != 8'sh80 && out_mouse_y != 8'sh80, "mouse out of range")

  // The selected delta is clamped.
  `TCDS_ASSERT_HOLDS(a_delta_range, out_valid, out_sel_delta_x <= 10'sd300 && out_sel_delta_x >= -10'sd300 && out_sel_delta_y <= 10'sd300 && out_sel_delta_y >= -10'sd300, "delta out of range")

endmodule

bind touch_cursor_delta_smoother_top tcds_checker u_tcds_checker (.*);

// ===== tb/touch_cursor_delta_smoother_top_tb.sv =====
`timescale 1ns / 1ps

module touch_cursor_delta_smoother_top_tb;
  import tcds_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int NUM_RANDOM     = 1200;

  // One expected cursor report.
  typedef struct packed {
    logic signed [DELTA_W-1:0] sel_dx;
    logic signed [DELTA_W-1:0] sel_dy;
    logic signed [DELTA_W-1:0] last_dx;
    logic signed [DELTA_W-1:0] last_dy;
    logic signed [MOUSE_W-1:0] mouse_x;
    logic signed [MOUSE_W-1:0] mouse_y;
    logic signed [MOUSE_W-1:0] prior_x;
    logic signed [MOUSE_W-1:0] prior_y;
    logic [STR_W-1:0]          peak;
    logic [COUNT_W-1:0]        count;
  } cursor_rep_t;

  // One trackpad report.
  typedef struct packed {
    logic [4:0][FINGER_W-1:0] finger;
    logic [COUNT_W-1:0]       count;
    logic [MS_W-1:0]          now;
  } pad_rep_t;

  // Directed row: report plus optional hand-written expectation.
  typedef struct {
    pad_rep_t    rep;
    bit          has_exp;
    cursor_rep_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FINGER_W-1:0] in_finger_a, in_finger_b, in_finger_c, in_finger_d, in_finger_e;
  logic [COUNT_W-1:0] in_finger_count;
  logic [MS_W-1:0] in_now_ms;
  logic out_valid;
  logic out_stall;
  logic signed [DELTA_W-1:0] out_sel_delta_x, out_sel_delta_y;
  logic signed [DELTA_W-1:0] out_last_delta_x, out_last_delta_y;
  logic signed [MOUSE_W-1:0] out_mouse_x, out_mouse_y;
  logic signed [MOUSE_W-1:0] out_prior_mouse_x, out_prior_mouse_y;
  logic [STR_W-1:0] out_peak_strength;
  logic [COUNT_W-1:0] out_count_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  touch_cursor_delta_smoother_top dut (.*);

  // Predictor state.
  int unsigned len_q, accel_q, gain_q, wait1_q, waitn_q;
  logic [15:0] pos_x[5], pos_y[5];
  bit          pos_ok[5];
  int          act_finger;
  logic [15:0] touch_t0;
  int          hx[HIST_DEPTH], hy[HIST_DEPTH];
  longint      carry_xq, carry_yq;
  int          prev_mx, prev_my;

  cursor_rep_t expected_q[$];
  bit          hand_exp_q[$];
  cursor_rep_t hand_val_q[$];
  int          n_errors;
  int          idle_cycles;
  bit          long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic void clear_tracking();
    for (int i = 0; i < 5; i++) begin
      pos_x[i] = '0; pos_y[i] = '0; pos_ok[i] = 1'b0;
    end
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hx[i] = 0; hy[i] = 0;
    end
    act_finger = 0; touch_t0 = '0;
    carry_xq = 0; carry_yq = 0; prev_mx = 0; prev_my = 0;
    len_q = 4; accel_q = 0; gain_q = 10; wait1_q = 50; waitn_q = 100;
  endfunction

  function automatic int clampi(longint v, longint lo, longint hi);
    return int'(v < lo ? lo : (v > hi ? hi : v));
  endfunction

  // Window sum, gain, carried division and saturation for one axis.
  function automatic int smooth_one(int delta, ref int hist[HIST_DEPTH], ref longint carry);
    longint sum, mag, lim, dv, total, mv;
    int unsigned n;
    n = len_q < 1 ? 1 : (len_q > HIST_DEPTH ? HIST_DEPTH : len_q);
    sum = delta;
    for (int i = 0; i + 1 < n; i++) sum += hist[i];
    if (accel_q[0]) begin
      mag = sum < 0 ? -sum : sum;
      lim = longint'(gain_q) * 100;
      dv = 100 * n;
      total = carry + sum * gain_q * mag;
      mv = total / dv;
      carry = total % dv;
      if (mv < -lim) mv = -lim;
      if (mv > lim) mv = lim;
    end else begin
      dv = 10 * n;
      total = carry + sum * gain_q;
      mv = total / dv;
      carry = total - mv * dv;
    end
    return clampi(clampi(mv, -1000, 1000), -HID_LIM, HID_LIM);
  endfunction

  function automatic cursor_rep_t predict_cursor(pad_rep_t r);
    cursor_rep_t o;
    int dx[5], dy[5];
    int fx, fy, st, peak, sx, sy, mx, my;
    bit fresh;
    logic [15:0] elapsed;
    peak = 0; fresh = 1'b1; sx = 0; sy = 0;
    for (int i = 0; i < 5; i++) begin
      fx = int'(r.finger[i][15:0]);
      fy = int'(r.finger[i][31:16]);
      st = int'(r.finger[i][47:32]);
      dx[i] = 0; dy[i] = 0;
      if (st > peak) peak = st;
      if (st == 0) begin
        pos_ok[i] = 1'b0;
      end else begin
        if (pos_ok[i]) begin
          fresh = 1'b0;
          dx[i] = clampi(fx - int'(pos_x[i]), -DELTA_LIM, DELTA_LIM);
          dy[i] = clampi(fy - int'(pos_y[i]), -DELTA_LIM, DELTA_LIM);
        end
        pos_x[i] = 16'(fx); pos_y[i] = 16'(fy); pos_ok[i] = 1'b1;
      end
    end
    if (r.count > 0 && fresh) touch_t0 = r.now;
    elapsed = r.now - touch_t0;
    if (r.count == 1 && elapsed < wait1_q) begin
      // Held after a fresh single touch.
    end else if (r.count >= 2 && elapsed < waitn_q) begin
      // Held after a fresh multi touch.
    end else if (act_finger < 5 &&
                 (dx[act_finger] < 0 ? -dx[act_finger] : dx[act_finger]) +
                 (dy[act_finger] < 0 ? -dy[act_finger] : dy[act_finger]) > MOVE_THRESH) begin
      sx = dx[act_finger]; sy = dy[act_finger];
    end else begin
      act_finger = NUM_FINGERS;
      for (int i = 4; i >= 0; i--)
        if ((dx[i] < 0 ? -dx[i] : dx[i]) + (dy[i] < 0 ? -dy[i] : dy[i]) > MOVE_THRESH)
          act_finger = i;
    end
    mx = smooth_one(sx, hx, carry_xq);
    my = smooth_one(sy, hy, carry_yq);
    o.sel_dx = DELTA_W'(sx); o.sel_dy = DELTA_W'(sy);
    o.last_dx = DELTA_W'(hx[0]); o.last_dy = DELTA_W'(hy[0]);
    o.mouse_x = MOUSE_W'(mx); o.mouse_y = MOUSE_W'(my);
    o.prior_x = MOUSE_W'(prev_mx); o.prior_y = MOUSE_W'(prev_my);
    o.peak = STR_W'(peak); o.count = r.count;
    for (int i = HIST_DEPTH - 1; i >= 1; i--) begin
      hx[i] = hx[i-1]; hy[i] = hy[i-1];
    end
    hx[0] = sx; hy[0] = sy;
    prev_mx = mx; prev_my = my;
    return o;
  endfunction

  function automatic logic [FINGER_W-1:0] pack_finger(int st, int y, int x);
    return {st[15:0], y[15:0], x[15:0]};
  endfunction

  // Result checker and output stall.
  initial begin
    cursor_rep_t want, got, hand;
    bit has_hand;
    int waitn;
    out_stall = 1'b1;
    waitn = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_sel_delta_x, out_sel_delta_y, out_last_delta_x, out_last_delta_y,
                out_mouse_x, out_mouse_y, out_prior_mouse_x, out_prior_mouse_y,
                out_peak_strength, out_count_out};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_q.pop_front();
          has_hand = hand_exp_q.pop_front();
          hand = hand_val_q.pop_front();
          if (has_hand && hand != want) report_mismatch("directed table", 1, 0);
          if (got.sel_dx != want.sel_dx) report_mismatch("sel_delta_x", got.sel_dx, want.sel_dx);
          if (got.sel_dy != want.sel_dy) report_mismatch("sel_delta_y", got.sel_dy, want.sel_dy);
          if (got.last_dx != want.last_dx)
            report_mismatch("last_delta_x", got.last_dx, want.last_dx);
          if (got.last_dy != want.last_dy)
            report_mismatch("last_delta_y", got.last_dy, want.last_dy);
          if (got.mouse_x != want.mouse_x) report_mismatch("mouse_x", got.mouse_x, want.mouse_x);
          if (got.mouse_y != want.mouse_y) report_mismatch("mouse_y", got.mouse_y, want.mouse_y);
          if (got.prior_x != want.prior_x)
            report_mismatch("prior_mouse_x", got.prior_x, want.prior_x);
          if (got.prior_y != want.prior_y)
            report_mismatch("prior_mouse_y", got.prior_y, want.prior_y);
          if (got.peak != want.peak) report_mismatch("peak_strength", got.peak, want.peak);
          if (got.count != want.count) report_mismatch("count_out", got.count, want.count);
        end
        waitn = $urandom_range(0, 8);
      end
      // Long hold-off once, counted here, so the block backs up.
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      if (waitn > 0) begin
        out_stall <= 1'b1;
        waitn--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("touch_cursor_delta_smoother_top regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SMOOTH_LEN:  len_q = val & 4'hF;
      CFG_ACCEL_ON:    accel_q = val & 1;
      CFG_SPEED_GAIN:  gain_q = val & 7'h7F;
      CFG_WAIT_SINGLE: wait1_q = val & 16'hFFFF;
      CFG_WAIT_MULTI:  waitn_q = val & 16'hFFFF;
      default: begin
      end
    endcase
  endtask

  // Valid stays up between back-to-back beats and drops only for a gap.
  task automatic send_report(input pad_rep_t r, input bit has_hand, input cursor_rep_t hand);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_finger_a, in_finger_b, in_finger_c, in_finger_d, in_finger_e} <=
      {r.finger[0], r.finger[1], r.finger[2], r.finger[3], r.finger[4]};
    in_finger_count <= r.count;
    in_now_ms <= r.now;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_cursor(r));
    hand_exp_q.push_back(has_hand);
    hand_val_q.push_back(hand);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random report: mostly a drag of one or more fingers with random steps.
  task automatic random_report(inout logic [15:0] t, inout int px[5], inout int py[5]);
    pad_rep_t r;
    int kind, st;
    kind = $urandom_range(0, 9);
    t = 16'(t + $urandom_range(0, 40));
    for (int i = 0; i < 5; i++) begin
      if (kind == 0) begin
        r.finger[i] = FINGER_W'({$urandom, $urandom});
      end else begin
        px[i] = (px[i] + $urandom_range(0, 80) - 40) & 16'hFFFF;
        py[i] = (py[i] + $urandom_range(0, 80) - 40) & 16'hFFFF;
        if ($urandom_range(0, 30) == 0) px[i] = $urandom_range(0, 65535);
        st = (i < 2 || $urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : 0;
        if ($urandom_range(0, 40) == 0) st = 0;
        r.finger[i] = pack_finger(st, py[i], px[i]);
      end
    end
    r.count = (kind == 1) ? COUNT_W'($urandom_range(0, 7)) : COUNT_W'($urandom_range(1, 3));
    r.now = (kind == 2) ? 16'($urandom) : t;
    send_report(r, 1'b0, '0);
  endtask

  // Stimulus.
  initial begin
    dir_row_t table_rows[$];
    dir_row_t row;
    logic [15:0] t;
    int px[5], py[5];
    int unsigned lens[4] = '{1, 10, 4, 0};
    int unsigned gains[4] = '{100, 0, 10, 127};
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_finger_a, in_finger_b, in_finger_c, in_finger_d, in_finger_e} = '0;
    in_finger_count = '0;
    in_now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SMOOTH_LEN;
    cfg_data = '0;
    n_errors = 0;
    long_hold = 1'b0;
    clear_tracking();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: fresh touch, hold, motion, finger change, extremes.
    row.has_exp = 1'b1;
    row.rep.finger = '0; row.rep.count = 0; row.rep.now = 0;
    row.exp = '0;
    table_rows.push_back(row);
    row.rep.finger[0] = pack_finger(16'hFFFF, 16'hFFFF, 16'hFFFF);
    row.rep.finger[4] = pack_finger(1, 0, 0);
    row.rep.count = 5; row.rep.now = 16'hFFFF;
    row.exp = '0; row.exp.peak = 16'hFFFF; row.exp.count = 5;
    table_rows.push_back(row);
    row.has_exp = 1'b0;
    for (int k = 0; k < 4; k++) begin
      row.rep.finger = '0;
      row.rep.finger[0] = pack_finger(500, 1000 + k * 400, 65535 - k * 500);
      row.rep.finger[1] = pack_finger(20, 100 + k, 100 + k * 2);
      row.rep.count = 2; row.rep.now = 16'(200 + k * 60);
      table_rows.push_back(row);
    end
    for (int k = 0; k < 4; k++) begin
      row.rep.finger = '0;
      row.rep.finger[0] = pack_finger(500, 2200, 63535);
      row.rep.finger[3] = pack_finger(9, 200 + k * 5, 300 - k * 5);
      row.rep.count = 7; row.rep.now = 16'(500 + k);
      table_rows.push_back(row);
    end
    row.rep.finger = '0; row.rep.finger[2] = pack_finger(1, 0, 0);
    row.rep.count = 1; row.rep.now = 16'd600;
    table_rows.push_back(row);
    row.rep.finger[2] = pack_finger(1, 2, 0); row.rep.now = 16'd700;
    table_rows.push_back(row);
    row.rep.finger[2] = pack_finger(1, 3, 1); row.rep.now = 16'd701;
    table_rows.push_back(row);
    row.rep.finger[2] = pack_finger(1, 3, 4); row.rep.now = 16'd702;
    table_rows.push_back(row);
    foreach (table_rows[k]) send_report(table_rows[k].rep, table_rows[k].has_exp,
                                        table_rows[k].exp);
    wait_idle();

    // Random phases across register settings, extremes included.
    t = 16'd800;
    for (int i = 0; i < 5; i++) begin
      px[i] = $urandom_range(0, 65535); py[i] = $urandom_range(0, 65535);
    end
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SMOOTH_LEN, ph < 4 ? lens[ph] : $urandom_range(0, 15));
      write_reg(CFG_ACCEL_ON, ph % 2);
      write_reg(CFG_SPEED_GAIN, ph < 4 ? gains[ph] : $urandom_range(0, 127));
      write_reg(CFG_WAIT_SINGLE, ph == 1 ? 16'hFFFF : (ph == 2 ? 0 : $urandom_range(0, 120)));
      write_reg(CFG_WAIT_MULTI, ph == 3 ? 16'hFFFF : (ph == 2 ? 0 : $urandom_range(0, 200)));
      if (ph == 5) long_hold = 1'b1;
      for (int n = 0; n < NUM_RANDOM / 8; n++) random_report(t, px, py);
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("touch_cursor_delta_smoother_top regression: pass");
    end else begin
      $display("touch_cursor_delta_smoother_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcds_pkg.sv
hw/rtl/tcds_finger_lane.sv
hw/rtl/tcds_merge.sv
hw/rtl/tcds_axis.sv
hw/rtl/touch_cursor_delta_smoother_top.sv
hw/rtl/tcds_checker.sv
tb/touch_cursor_delta_smoother_top_tb.sv
